FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the allocator core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/bth_pkg.sv
// ---------------------------------------------------------------------------
// bth_pkg
// Types and constants of the boundary tag heap allocator.
// ---------------------------------------------------------------------------
package bth_pkg;

    localparam logic [2:0] FLAG_MASK  = 3'b111;
    localparam logic [2:0] TAKEN_FLAG = 3'b001;
    localparam int         WORD_BYTES = 8;
    localparam int         TAG_W      = 16;
    localparam int         SZW_W      = 13;
    localparam int         SUM_W      = 14;
    localparam int         LEN_W      = 8;
    localparam int         OFF_W      = 10;
    localparam int         POS_W      = 17;
    localparam int         NSLOT      = 6;
    localparam logic       REQ_ALLOC   = 1'b0;
    localparam logic       REQ_RELEASE = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRD,
        S_WCHK,
        S_PRD,
        S_PCHK,
        S_NRD,
        S_NCHK,
        S_SETUP,
        S_WRITE,
        S_DONE
    } t_state;

endpackage

FILE: rtl/bth_req_if.sv
// ---------------------------------------------------------------------------
// bth_req_if
// Request channel: allocate or release item with valid/ready transfer.
// ---------------------------------------------------------------------------
interface bth_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [9:0] request_bytes;
    logic [9:0] release_offset;

    modport source (output valid, req_type, request_bytes, release_offset, input ready);
    modport sink   (input valid, req_type, request_bytes, release_offset, output ready);
endinterface

FILE: rtl/bth_rsp_if.sv
// ---------------------------------------------------------------------------
// bth_rsp_if
// Response channel: granted offset and status with valid/ready transfer.
// ---------------------------------------------------------------------------
interface bth_rsp_if;
    logic       valid;
    logic       ready;
    logic [9:0] payload_offset;
    logic       granted;

    modport source (output valid, payload_offset, granted, input ready);
    modport sink   (input valid, payload_offset, granted, output ready);
endinterface

FILE: rtl/boundary_tag_heap_allocator_core.sv
// ---------------------------------------------------------------------------
// boundary_tag_heap_allocator_core
// First-fit boundary tag allocator with coalescing release.
//
//  channel | dir | fields
//  i_req   | in  | req_type, request_bytes, release_offset
//  o_rsp   | out | payload_offset, granted
//
// After reset a clearing pass rebuilds the heap; no request is taken meanwhile.
// Allocate: accept, then a read (S_WRD) and a check (S_WCHK) per block header
// visited, the write slots in turn (S_WRITE) on a hit, and S_DONE to post the
// response. Release: the same walk, then, where they apply, the neighbor reads
// and checks (S_PRD, S_PCHK, S_NRD, S_NCHK), S_SETUP and the write slots in turn.
// The tag memory ports set this order; a waiting response stalls only the next acceptance.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module boundary_tag_heap_allocator_core
    import bth_pkg::*;
#(
    parameter int HEAP_BYTES = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bth_req_if.sink    i_req,
    bth_rsp_if.source  o_rsp
);

    localparam int HEAP_WORDS = HEAP_BYTES / WORD_BYTES;
    localparam int AW         = $clog2(HEAP_WORDS);
    localparam int WW         = AW + 1;

    t_state r_state, n_state;

    logic [WW-1:0]    r_w;
    logic [SZW_W-1:0] r_sz, r_psz, r_nsz;
    logic [LEN_W-1:0] r_len;
    logic [OFF_W-1:0] r_off;
    logic             r_kind, r_mp, r_mn;
    logic [2:0]       r_step;
    logic [AW-1:0]    r_clr;
    logic [AW-1:0]    r_wa [NSLOT];
    logic [TAG_W-1:0] r_wd [NSLOT];
    logic             r_we [NSLOT];
    logic             r_grant;
    logic [OFF_W-1:0] r_pay;
    logic             r_ovalid, r_ogr;
    logic [OFF_W-1:0] r_opay;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [TAG_W-1:0] mem_wdata, rdata;

    logic [SZW_W-1:0] t_szw;
    logic [2:0]       t_flg;
    logic [SUM_W-1:0] s_end, s_nend, s_blk_end;
    logic             bad, at_end, alloc_hit, off_hit;
    logic [POS_W-1:0] pos;
    logic [SZW_W-1:0] rem;
    logic [SUM_W-1:0] rel_start, rel_size;
    logic             in_xfer;
    logic [LEN_W-1:0] n_len;

    bth_tag_ram #(.DEPTH(HEAP_WORDS), .AW(AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(rdata)
    );

    assign t_szw     = rdata[TAG_W-1:3];
    assign t_flg     = rdata[2:0] & FLAG_MASK;
    assign s_end     = SUM_W'(r_w) + SUM_W'(t_szw);
    assign s_blk_end = SUM_W'(r_w) + SUM_W'(r_sz);
    assign s_nend    = s_blk_end + SUM_W'(t_szw);
    assign bad       = (t_szw == '0) || (s_end > SUM_W'(HEAP_WORDS));
    assign at_end    = (SUM_W'(r_w) >= SUM_W'(HEAP_WORDS));
    assign alloc_hit = (t_flg == '0) && (t_szw >= SZW_W'(r_len));
    assign pos       = POS_W'({r_w, 3'b000}) + POS_W'(WORD_BYTES);
    assign off_hit   = (pos == POS_W'(r_off));
    assign rem       = t_szw - SZW_W'(r_len);
    assign rel_start = r_mp ? (SUM_W'(r_w) - SUM_W'(r_psz)) : SUM_W'(r_w);
    assign rel_size  = SUM_W'(r_sz) + (r_mp ? SUM_W'(r_psz) : '0)
                     + (r_mn ? SUM_W'(r_nsz) : '0);

    assign i_req.ready = (r_state == S_IDLE) && (!r_ovalid || o_rsp.ready);
    assign in_xfer     = i_req.valid && i_req.ready;
    assign n_len = (i_req.request_bytes == '0) ? LEN_W'(2)
                 : LEN_W'(((11'(i_req.request_bytes) + 11'd7) >> 3) + 11'd1);

    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.payload_offset = r_opay;
    assign o_rsp.granted        = r_ogr;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == AW'(HEAP_WORDS - 1)) n_state = S_IDLE;
            S_IDLE:  if (in_xfer) n_state = S_WRD;
            S_WRD:   n_state = at_end ? S_DONE : S_WCHK;
            S_WCHK: begin
                if (bad) begin
                    n_state = S_DONE;
                end else if (r_kind == REQ_ALLOC) begin
                    n_state = alloc_hit ? S_WRITE : S_WRD;
                end else if (off_hit) begin
                    n_state = (t_flg != '0) ? S_PRD : S_DONE;
                end else begin
                    n_state = S_WRD;
                end
            end
            S_PRD:   n_state = (r_w == '0) ? S_NRD : S_PCHK;
            S_PCHK:  n_state = S_NRD;
            S_NRD:   n_state = (s_blk_end < SUM_W'(HEAP_WORDS)) ? S_NCHK : S_SETUP;
            S_NCHK:  n_state = S_SETUP;
            S_SETUP: n_state = S_WRITE;
            S_WRITE: if (r_step == 3'(NSLOT - 1)) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = '0;
        mem_raddr = AW'(r_w);
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = ((r_clr == '0) || (r_clr == AW'(HEAP_WORDS - 1)))
                          ? TAG_W'(HEAP_BYTES) : '0;
            end
            S_PRD:   mem_raddr = AW'(r_w - WW'(1));
            S_NRD:   mem_raddr = AW'(s_blk_end);
            S_WRITE: begin
                mem_we    = r_we[r_step];
                mem_waddr = r_wa[r_step];
                mem_wdata = r_wd[r_step];
            end
            S_IDLE, S_WRD, S_WCHK, S_PCHK, S_NCHK, S_SETUP, S_DONE: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_step   <= '0;
        end else begin
            r_state <= n_state;
            if (o_rsp.ready && r_state != S_DONE) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + AW'(1);
                S_IDLE: begin
                    if (in_xfer) begin
                        r_kind  <= i_req.req_type;
                        r_len   <= n_len;
                        r_off   <= i_req.release_offset;
                        r_w     <= '0;
                        r_mp    <= 1'b0;
                        r_mn    <= 1'b0;
                        r_grant <= 1'b0;
                        r_pay   <= '0;
                        r_step  <= '0;
                    end
                end
                S_WCHK: begin
                    if (!bad && r_kind == REQ_ALLOC && alloc_hit) begin
                        r_grant <= 1'b1;
                        r_pay   <= OFF_W'(pos);
                        r_we[0] <= 1'b0;
                        r_we[1] <= 1'b0;
                        r_we[2] <= 1'b1;
                        r_we[3] <= 1'b1;
                        r_wa[2] <= AW'(r_w);
                        if (rem != '0) begin
                            r_wd[2] <= {SZW_W'(r_len), TAKEN_FLAG};
                            r_wa[3] <= AW'(SUM_W'(r_w) + SUM_W'(r_len) - SUM_W'(1));
                            r_wd[3] <= {SZW_W'(r_len), TAKEN_FLAG};
                            r_we[4] <= 1'b1;
                            r_wa[4] <= AW'(SUM_W'(r_w) + SUM_W'(r_len));
                            r_wd[4] <= {rem, 3'b000};
                            r_we[5] <= 1'b1;
                            r_wa[5] <= AW'(s_end - SUM_W'(1));
                            r_wd[5] <= {rem, 3'b000};
                        end else begin
                            r_wd[2] <= {t_szw, TAKEN_FLAG};
                            r_wa[3] <= AW'(s_end - SUM_W'(1));
                            r_wd[3] <= {t_szw, TAKEN_FLAG};
                            r_we[4] <= 1'b0;
                            r_we[5] <= 1'b0;
                        end
                    end else if (!bad && r_kind == REQ_RELEASE && off_hit) begin
                        r_sz <= t_szw;
                    end else if (!bad) begin
                        r_w <= WW'(s_end);
                    end
                end
                S_PCHK: begin
                    r_psz <= t_szw;
                    r_mp  <= (t_flg == '0) && (t_szw != '0) && (t_szw <= SZW_W'(r_w));
                end
                S_NCHK: begin
                    r_nsz <= t_szw;
                    r_mn  <= (t_flg == '0) && (t_szw != '0)
                          && (s_nend <= SUM_W'(HEAP_WORDS));
                end
                S_SETUP: begin
                    r_grant <= 1'b1;
                    r_we[0] <= r_mp;
                    r_wa[0] <= AW'(r_w - WW'(1));
                    r_wd[0] <= '0;
                    r_we[1] <= r_mp;
                    r_wa[1] <= AW'(r_w);
                    r_wd[1] <= '0;
                    r_we[2] <= r_mn;
                    r_wa[2] <= AW'(s_blk_end - SUM_W'(1));
                    r_wd[2] <= '0;
                    r_we[3] <= r_mn;
                    r_wa[3] <= AW'(s_blk_end);
                    r_wd[3] <= '0;
                    r_we[4] <= 1'b1;
                    r_wa[4] <= AW'(rel_start);
                    r_wd[4] <= {SZW_W'(rel_size), 3'b000};
                    r_we[5] <= 1'b1;
                    r_wa[5] <= AW'(rel_start + rel_size - SUM_W'(1));
                    r_wd[5] <= {SZW_W'(rel_size), 3'b000};
                end
                S_WRITE: r_step <= r_step + 3'd1;
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_opay   <= r_pay;
                    r_ogr    <= r_grant;
                end
                S_WRD, S_PRD, S_NRD: begin
                    r_step <= r_step;
                end
            endcase
        end
    end

    `AST_IMPL(a_clear_blocks, i_clk, i_rst_n, r_state == S_CLEAR, !i_req.ready)
    `AST_NEXT(a_accept_walks, i_clk, i_rst_n, in_xfer, r_state == S_WRD)
    `AST_IMPL(a_fail_zero, i_clk, i_rst_n, o_rsp.valid && !o_rsp.granted,
              o_rsp.payload_offset == '0)
    `AST_NEXT(a_done_shows, i_clk, i_rst_n, r_state == S_DONE, o_rsp.valid)

endmodule

FILE: rtl/bth_tag_ram.sv
// ---------------------------------------------------------------------------
// bth_tag_ram
// Tag word memory: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module bth_tag_ram
    import bth_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [TAG_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [TAG_W-1:0] o_rdata
);

    logic [TAG_W-1:0] r_mem [DEPTH];
    logic [TAG_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the boundary tag heap allocator core against a behavioral heap model.
// A directed table covers the edge cases: zero-length and oversize allocates,
// bad releases and releases at the heap edges. Random allocate/release traffic
// follows. Both channels idle at random. Responses are checked in order.
// ----------------------------------------------------------------------------
module tb
    import bth_pkg::*;
();

    localparam int HEAP_BYTES = 1024;
    localparam int HEAP_WORDS = HEAP_BYTES / 8;
    localparam int NUM_RANDOM = 600;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic       kind;
        logic [9:0] nbytes;
        logic [9:0] offset;
        logic       check;
        logic [9:0] exp_off;
        logic       exp_grant;
    } t_row;

    typedef struct packed {
        logic [9:0] off;
        logic       grant;
    } t_grant;

    logic i_clk;
    logic i_rst_n;
    bth_req_if req_ch ();
    bth_rsp_if rsp_ch ();

    boundary_tag_heap_allocator_core #(.HEAP_BYTES(HEAP_BYTES)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    logic [15:0] heap_model [HEAP_WORDS];
    t_grant      grant_queue [$];
    t_row        table_rows [$];
    logic [9:0]  live_offsets [$];
    int          fails;
    int          idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int tag_bytes(logic [15:0] t);
        return int'(t & 16'hFFF8);
    endfunction

    function automatic void put_block(int w, int nb, logic [2:0] flag);
        int last;
        if (nb < 8 || w >= HEAP_WORDS) return;
        last = w + nb / 8 - 1;
        if (last >= HEAP_WORDS) return;
        heap_model[w]    = 16'(nb) | 16'(flag);
        heap_model[last] = 16'(nb) | 16'(flag);
    endfunction

    function automatic int size_at(int w);
        int sz;
        sz = tag_bytes(heap_model[w]);
        if (sz == 0 || w + sz / 8 > HEAP_WORDS) return 0;
        return sz;
    endfunction

    function automatic void heap_clear();
        for (int i = 0; i < HEAP_WORDS; i++) heap_model[i] = '0;
        put_block(0, HEAP_BYTES, 3'b000);
    endfunction

    function automatic t_grant heap_allocate(logic [9:0] nb);
        t_grant r;
        int len, w, sz, rem;
        r = '0;
        len = (nb == 0) ? 8 : int'(nb);
        len = ((len + 7) & ~7) + 8;
        w = 0;
        while (w < HEAP_WORDS) begin
            sz = size_at(w);
            if (sz == 0) break;
            if ((heap_model[w][2:0] & FLAG_MASK) == 3'b000 && sz >= len) begin
                rem = sz - len;
                if (rem >= 8) begin
                    put_block(w, len, TAKEN_FLAG);
                    put_block(w + len / 8, rem, 3'b000);
                end else begin
                    put_block(w, sz, TAKEN_FLAG);
                end
                r.off = 10'(w * 8 + 8);
                r.grant = 1'b1;
                return r;
            end
            w += sz / 8;
        end
        return r;
    endfunction

    function automatic t_grant heap_release(logic [9:0] off);
        t_grant r;
        int w, sz, start, total, stop, psz, nsz;
        bit found, mprev, mnext;
        r = '0;
        w = 0;
        sz = 0;
        found = 0;
        while (w < HEAP_WORDS) begin
            sz = size_at(w);
            if (sz == 0) break;
            if (w * 8 + 8 == int'(off)) begin
                found = (heap_model[w][2:0] & FLAG_MASK) != 3'b000;
                break;
            end
            w += sz / 8;
        end
        if (!found) return r;
        start = w;
        total = sz;
        stop = w + sz / 8;
        mprev = 0;
        mnext = 0;
        psz = 0;
        nsz = 0;
        if (w > 0 && (heap_model[w-1][2:0] & FLAG_MASK) == 3'b000) begin
            psz = tag_bytes(heap_model[w-1]);
            mprev = psz != 0 && psz / 8 <= w;
        end
        if (stop < HEAP_WORDS && (heap_model[stop][2:0] & FLAG_MASK) == 3'b000) begin
            nsz = size_at(stop);
            mnext = nsz != 0;
        end
        if (mprev) begin
            heap_model[w-1] = '0;
            heap_model[w] = '0;
            start = w - psz / 8;
            total += psz;
        end
        if (mnext) begin
            heap_model[stop-1] = '0;
            heap_model[stop] = '0;
            total += nsz;
        end
        put_block(start, total, 3'b000);
        r.grant = 1'b1;
        return r;
    endfunction

    function automatic t_row mk(logic k, int nb, int off, logic chk, int eo, logic eg);
        t_row r;
        r.kind = k;
        r.nbytes = 10'(nb);
        r.offset = 10'(off);
        r.check = chk;
        r.exp_off = 10'(eo);
        r.exp_grant = eg;
        return r;
    endfunction

    task automatic send_item(logic k, logic [9:0] nb, logic [9:0] off, t_row row);
        t_grant g;
        repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18)) @(negedge i_clk);
        req_ch.valid = 1'b1;
        req_ch.req_type = k;
        req_ch.request_bytes = nb;
        req_ch.release_offset = off;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        g = (k == REQ_ALLOC) ? heap_allocate(nb) : heap_release(off);
        if (k == REQ_ALLOC && g.grant) live_offsets.push_back(g.off);
        if (row.check) begin
            g.off = row.exp_off;
            g.grant = row.exp_grant;
        end
        grant_queue.push_back(g);
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        req_ch.req_type = $urandom_range(0, 1);
        req_ch.request_bytes = 10'($urandom);
        req_ch.release_offset = 10'($urandom);
    endtask

    initial begin
        int wait_left;
        wait_left = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (wait_left > 0) begin
                wait_left--;
                rsp_ch.ready = 1'b0;
            end else begin
                rsp_ch.ready = 1'b1;
            end
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready)
                wait_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        end
    end

    always @(posedge i_clk) begin
        t_grant e;
        if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (grant_queue.size() == 0) begin
                $error("unexpected response: payload_offset %0d granted %0d",
                       rsp_ch.payload_offset, rsp_ch.granted);
                fails++;
            end else begin
                e = grant_queue.pop_front();
                if (rsp_ch.payload_offset !== e.off) begin
                    $error("payload_offset expected %0d actual %0d", e.off,
                           rsp_ch.payload_offset);
                    fails++;
                end
                if (rsp_ch.granted !== e.grant) begin
                    $error("granted expected %0d actual %0d", e.grant, rsp_ch.granted);
                    fails++;
                end
            end
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_row row;
        logic k;
        logic [9:0] nb, off;
        int pick;
        fails = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_ALLOC;
        req_ch.request_bytes = '0;
        req_ch.release_offset = '0;
        heap_clear();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        table_rows.push_back(mk(REQ_RELEASE, 0, 8, 1, 0, 0));
        table_rows.push_back(mk(REQ_ALLOC, 0, 0, 1, 8, 1));
        table_rows.push_back(mk(REQ_ALLOC, 1, 0, 1, 24, 1));
        table_rows.push_back(mk(REQ_ALLOC, 1016, 0, 1, 0, 0));
        table_rows.push_back(mk(REQ_ALLOC, 7, 0, 0, 0, 0));
        table_rows.push_back(mk(REQ_RELEASE, 0, 0, 1, 0, 0));
        table_rows.push_back(mk(REQ_RELEASE, 0, 13, 1, 0, 0));
        table_rows.push_back(mk(REQ_RELEASE, 0, 16, 1, 0, 0));
        table_rows.push_back(mk(REQ_RELEASE, 0, 24, 0, 0, 0));
        table_rows.push_back(mk(REQ_RELEASE, 0, 24, 1, 0, 0));
        table_rows.push_back(mk(REQ_RELEASE, 0, 8, 0, 0, 0));
        table_rows.push_back(mk(REQ_RELEASE, 0, 40, 0, 0, 0));
        table_rows.push_back(mk(REQ_ALLOC, 1008, 0, 1, 8, 1));
        table_rows.push_back(mk(REQ_ALLOC, 0, 0, 1, 0, 0));
        table_rows.push_back(mk(REQ_RELEASE, 0, 8, 1, 0, 1));
        table_rows.push_back(mk(REQ_ALLOC, 1000, 0, 1, 8, 1));
        table_rows.push_back(mk(REQ_ALLOC, 0, 0, 1, 1016, 1));
        table_rows.push_back(mk(REQ_RELEASE, 0, 1016, 1, 0, 1));
        table_rows.push_back(mk(REQ_RELEASE, 0, 8, 1, 0, 1));
        table_rows.push_back(mk(REQ_ALLOC, 1023, 0, 1, 0, 0));
        table_rows.push_back(mk(REQ_ALLOC, 512, 0, 0, 0, 0));
        table_rows.push_back(mk(REQ_ALLOC, 1, 0, 0, 0, 0));
        table_rows.push_back(mk(REQ_RELEASE, 0, 8, 0, 0, 0));
        table_rows.push_back(mk(REQ_RELEASE, 0, 536, 0, 0, 0));
        foreach (table_rows[i])
            send_item(table_rows[i].kind, table_rows[i].nbytes, table_rows[i].offset,
                      table_rows[i]);
        live_offsets.delete();

        for (int n = 0; n < NUM_RANDOM; n++) begin
            row = '0;
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                k = REQ_ALLOC;
                nb = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 120));
                off = 10'($urandom);
            end else if (pick < 88 && live_offsets.size() > 0) begin
                k = REQ_RELEASE;
                nb = 10'($urandom);
                pick = $urandom_range(0, live_offsets.size() - 1);
                off = live_offsets[pick];
                live_offsets.delete(pick);
            end else begin
                k = REQ_RELEASE;
                nb = 10'($urandom);
                off = ($urandom_range(0, 1) == 0) ? 10'($urandom) : 10'($urandom_range(0, 127) * 8);
            end
            send_item(k, nb, off, row);
        end
        while (grant_queue.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fails == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
